### design/tss_pkg.sv
package tss_pkg;

    localparam int TOTAL_SLOTS = 48;
    localparam int REGION_MAX  = TOTAL_SLOTS / 3;
    localparam int ADDR_W      = $clog2(TOTAL_SLOTS);
    localparam int TOP_W       = $clog2(TOTAL_SLOTS + 1);
    localparam int SIZE_W      = 5;
    localparam int CALC_W      = (TOP_W > SIZE_W) ? TOP_W : SIZE_W;
    localparam int WORD_W      = 32;

    localparam int SIZE_RESET  = 4;
    localparam int EFF_RESET   = (SIZE_RESET > REGION_MAX) ? REGION_MAX : SIZE_RESET;

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    localparam logic [1:0] SEL_NONE   = 2'd0;
    localparam logic [1:0] SEL_ONE    = 2'd1;
    localparam logic [1:0] SEL_TWO    = 2'd2;
    localparam logic [1:0] SEL_THREE  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_INVALID   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [1:0]               cmd;
        logic [1:0]               stack_sel;
        logic signed [WORD_W-1:0] value;
    } tss_item_t;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [WORD_W-1:0] data;
    } tss_result_t;

    typedef struct packed {
        logic                     we;
        logic [ADDR_W-1:0]        waddr;
        logic signed [WORD_W-1:0] wdata;
        logic [ADDR_W-1:0]        raddr;
    } tss_mem_req_t;

endpackage

### design/tss_mem.sv
module tss_mem
    import tss_pkg::*;
(
    input  logic                     clk,
    input  tss_mem_req_t             req,
    output logic signed [WORD_W-1:0] rdata
);

    logic signed [WORD_W-1:0] mem [TOTAL_SLOTS];
    logic signed [WORD_W-1:0] rdata_reg;

    // one write port, one read port, registered read data
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/tss_ctrl.sv
module tss_ctrl
    import tss_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  tss_item_t                item,
    output logic                     done,
    output tss_result_t              result,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [SIZE_W-1:0]        cfg_data,
    output tss_mem_req_t             mem_req,
    input  logic signed [WORD_W-1:0] mem_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SEARCH
    } state_t;

    state_t                   state_reg, state_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    tss_result_t              result_reg, result_next;
    logic [SIZE_W-1:0]        size_reg, size_next;
    logic [TOP_W-1:0]         top_reg [3];
    logic [TOP_W-1:0]         top_next [3];
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic [ADDR_W-1:0]        base_reg, base_next;
    logic signed [WORD_W-1:0] value_reg, value_next;

    logic                     accept;
    logic [CALC_W-1:0]        eff_size;
    logic [CALC_W-1:0]        base_c;
    logic [CALC_W-1:0]        limit_c;
    logic [CALC_W-1:0]        top_c;
    logic [1:0]               sel_idx;

    assign accept    = start && !busy_reg;
    assign cfg_ready = !busy_reg;
    assign busy      = busy_reg;
    assign done      = done_reg;
    assign result    = result_reg;
    assign sel_idx   = item.stack_sel - 2'd1;

    always_comb
    begin
        if (CALC_W'(size_reg) > CALC_W'(REGION_MAX))
        begin
            eff_size = CALC_W'(REGION_MAX);
        end
        else
        begin
            eff_size = CALC_W'(size_reg);
        end
    end

    // region base and current top of the selected stack
    always_comb
    begin
        unique case (item.stack_sel)
            SEL_ONE:
            begin
                base_c = '0;
                top_c  = CALC_W'(top_reg[0]);
            end
            SEL_TWO:
            begin
                base_c = eff_size;
                top_c  = CALC_W'(top_reg[1]);
            end
            SEL_THREE:
            begin
                base_c = eff_size << 1;
                top_c  = CALC_W'(top_reg[2]);
            end
            default:
            begin
                base_c = '0;
                top_c  = '0;
            end
        endcase
        limit_c = base_c + eff_size;
    end

    always_comb
    begin
        state_next  = state_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        size_next   = size_reg;
        top_next    = top_reg;
        idx_next    = idx_reg;
        base_next   = base_reg;
        value_next  = value_reg;
        mem_req     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next   = 1'b1;
                    result_next = '{status: ST_OK, data: '0};
                    if (item.stack_sel == SEL_NONE)
                    begin
                        result_next.status = ST_INVALID;
                    end
                    else
                    begin
                        case (item.cmd)
                            CMD_PUSH:
                            begin
                                if (top_c >= limit_c)
                                begin
                                    result_next.status = ST_FULL;
                                end
                                else
                                begin
                                    mem_req.we        = 1'b1;
                                    mem_req.waddr     = ADDR_W'(top_c);
                                    mem_req.wdata     = item.value;
                                    top_next[sel_idx] = TOP_W'(top_c + 1'b1);
                                end
                            end
                            CMD_POP:
                            begin
                                if (top_c <= base_c)
                                begin
                                    result_next.status = ST_EMPTY;
                                end
                                else
                                begin
                                    done_next         = 1'b0;
                                    busy_next         = 1'b1;
                                    state_next        = S_POP;
                                    mem_req.raddr     = ADDR_W'(top_c - 1'b1);
                                    idx_next          = ADDR_W'(top_c - 1'b1);
                                    top_next[sel_idx] = TOP_W'(top_c - 1'b1);
                                end
                            end
                            CMD_SEARCH:
                            begin
                                if (top_c <= base_c)
                                begin
                                    result_next.status = ST_NOT_FOUND;
                                end
                                else
                                begin
                                    done_next     = 1'b0;
                                    busy_next     = 1'b1;
                                    state_next    = S_SEARCH;
                                    mem_req.raddr = ADDR_W'(top_c - 1'b1);
                                    idx_next      = ADDR_W'(top_c - 1'b1);
                                    base_next     = ADDR_W'(base_c);
                                    value_next    = item.value;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                if (cfg_valid && cfg_ready)
                begin
                    size_next = cfg_data;
                    if (CALC_W'(cfg_data) > CALC_W'(REGION_MAX))
                    begin
                        top_next[0] = '0;
                        top_next[1] = TOP_W'(REGION_MAX);
                        top_next[2] = TOP_W'(2 * REGION_MAX);
                    end
                    else
                    begin
                        top_next[0] = '0;
                        top_next[1] = TOP_W'(cfg_data);
                        top_next[2] = TOP_W'({1'b0, cfg_data} << 1);
                    end
                end
            end

            S_POP:
            begin
                // read data of the old top is here: return it, clear the slot
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg;
                mem_req.wdata = '0;
                result_next   = '{status: ST_OK, data: mem_rdata};
                done_next     = 1'b1;
                busy_next     = 1'b0;
                state_next    = S_IDLE;
            end

            S_SEARCH:
            begin
                if (mem_rdata == value_reg)
                begin
                    result_next = '{status: ST_OK, data: mem_rdata};
                    done_next   = 1'b1;
                    busy_next   = 1'b0;
                    state_next  = S_IDLE;
                end
                else if (idx_reg == base_reg)
                begin
                    result_next = '{status: ST_NOT_FOUND, data: '0};
                    done_next   = 1'b1;
                    busy_next   = 1'b0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    // fetch the next lower entry while this one is compared
                    mem_req.raddr = idx_reg - 1'b1;
                    idx_next      = idx_reg - 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            result_reg <= '0;
            size_reg   <= SIZE_W'(SIZE_RESET);
            top_reg[0] <= '0;
            top_reg[1] <= TOP_W'(EFF_RESET);
            top_reg[2] <= TOP_W'(2 * EFF_RESET);
        end
        else
        begin
            state_reg  <= state_next;
            busy_reg   <= busy_next;
            done_reg   <= done_next;
            result_reg <= result_next;
            size_reg   <= size_next;
            top_reg    <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        base_reg  <= base_next;
        value_reg <= value_next;
    end

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(done_reg && busy_reg))
        else $error("result strobe while still busy");

    a_push_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.cmd == CMD_PUSH) |=> done_reg)
        else $error("push result not given in the next cycle");

    a_pop_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |=> (done_reg && !busy_reg))
        else $error("pop did not finish after its memory read");

    a_tops_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (top_reg[0] <= top_reg[1]) && (top_reg[1] <= top_reg[2])
        && (CALC_W'(top_reg[2]) <= CALC_W'(TOTAL_SLOTS)))
        else $error("stack tops out of order or beyond memory");

    a_search_idx_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (idx_reg >= base_reg))
        else $error("search walked below the region base");

endmodule

### design/three_stacks_shared_memory.sv
// Three stacks in one shared word memory.
//
// Command channel: present item (cmd, stack_sel, value) with start high;
// the transfer happens at a rising edge where start is high and busy is low.
// Each command yields exactly one result on the result port, flagged by a
// one-cycle done strobe. The receiver cannot stall, so take the result in
// the cycle it is shown.
// Results and throughput by command:
//   push, invalid stack, unused command, full/empty cases: result strobed
//   in the following cycle; busy stays low, so these can go back to back;
//   pop: read the top word, then clear its slot, with busy high meanwhile;
//   search: k entries compared, at most the region size (16), busy high.
// The memory has a single read port and reads one word per cycle.
// Configuration: a cfg_valid/cfg_ready transfer writes stack_size and moves
// all tops back to their region bases; memory contents stay. cfg_ready is low
// while a pop or search is in progress.
// Reset: tops go to 0, 4, 8 (size 4). No memory clear is needed: only words
// pushed since the last rebase are ever read back.
module three_stacks_shared_memory
    import tss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tss_item_t         item,
    output logic              done,
    output tss_result_t       result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SIZE_W-1:0] cfg_data
);

    // memory request from control, registered read data back in the next cycle
    tss_mem_req_t             mem_req;
    logic signed [WORD_W-1:0] mem_rdata;

    // command decode, top pointers, search walk and result register
    tss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    // shared word store for all three regions
    tss_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

endmodule

### verif/tb_three_stacks_shared_memory.sv
`timescale 1ns / 100ps

module tb_three_stacks_shared_memory;
    import tss_pkg::*;

    // cmd value 3 is not decoded by the block: on a valid stack it must answer ok with zero data
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // Longest quiet stretch of a correct run is a full search plus the longest
    // sender gap plus the settle pause; allow many times that.
    localparam int WATCHDOG_LIMIT = 1000;
    // Hold this long after the last result before touching the size register
    // and before the final verdict, so that a trailing pop clear or search
    // walk is surely finished.
    localparam int SETTLE_CYCLES  = 20;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    tss_item_t         item      = '0;
    logic              done;
    tss_result_t       result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [SIZE_W-1:0] cfg_data  = '0;

    // Shadow of the block: word memory, top pointers and the size register
    logic signed [WORD_W-1:0] stack_words [TOTAL_SLOTS];
    int unsigned              top_slot [3];
    logic [SIZE_W-1:0]        size_setting;

    // Results owed by the block, oldest first
    tss_result_t outcomes_due [$];

    int fail_count   = 0;
    int quiet_cycles = 0;
    bit steady_flow  = 1'b0;

    three_stacks_shared_memory uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------

    // Sizes above a third of the memory saturate; the register keeps its value.
    function automatic int unsigned region_slots();
        return (size_setting > REGION_MAX) ? REGION_MAX : int'(size_setting);
    endfunction

    // Move every top back to its region base for the current size.
    function automatic void rebase_tops();
        int unsigned eff;
        eff = region_slots();
        top_slot[0] = 0;
        top_slot[1] = eff;
        top_slot[2] = 2 * eff;
    endfunction

    // Apply one command to the shadow and return the result it owes.
    function automatic tss_result_t stack_op_outcome(input tss_item_t req);
        tss_result_t res;
        int unsigned eff, base, limit, slot, pos;
        bit          hit;
        res.status = ST_OK;
        res.data   = '0;
        if (req.stack_sel == SEL_NONE)
        begin
            res.status = ST_INVALID;
        end
        else
        begin
            eff   = region_slots();
            slot  = int'(req.stack_sel) - 1;
            base  = slot * eff;
            limit = base + eff;
            case (req.cmd)
                CMD_PUSH:
                begin
                    if (top_slot[slot] >= limit || top_slot[slot] >= TOTAL_SLOTS)
                        res.status = ST_FULL;
                    else
                    begin
                        stack_words[top_slot[slot]] = req.value;
                        top_slot[slot]++;
                    end
                end
                CMD_POP:
                begin
                    if (top_slot[slot] <= base || top_slot[slot] > TOTAL_SLOTS)
                        res.status = ST_EMPTY;
                    else
                    begin
                        top_slot[slot]--;
                        res.data = stack_words[top_slot[slot]];
                        stack_words[top_slot[slot]] = '0;
                    end
                end
                CMD_SEARCH:
                begin
                    // walk top to bottom, bottom entry included
                    pos = (top_slot[slot] > TOTAL_SLOTS) ? TOTAL_SLOTS : top_slot[slot];
                    hit = 1'b0;
                    while (pos > base && !hit)
                    begin
                        pos--;
                        if (stack_words[pos] == req.value)
                        begin
                            hit      = 1'b1;
                            res.data = stack_words[pos];
                        end
                    end
                    if (!hit)
                        res.status = ST_NOT_FOUND;
                end
                default: ;
            endcase
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Send one command: idle for a random gap, present it, hold until the
    // transfer, then book the owed result. start stays high afterwards so a
    // zero gap gives back-to-back transfers.
    task automatic send_op(input logic [1:0] op, input logic [1:0] sel,
                           input logic signed [WORD_W-1:0] word);
        tss_item_t req;
        int        gap;
        req.cmd       = op;
        req.stack_sel = sel;
        req.value     = word;
        gap = steady_flow ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= req;
        do @(posedge clk); while (busy);
        outcomes_due.push_back(stack_op_outcome(req));
    endtask

    // Drop start, wait for every owed result, then let the block settle.
    task automatic drain_and_settle();
        start <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the size register with the block idle; all tops rebase.
    task automatic write_stack_size(input logic [SIZE_W-1:0] size);
        drain_and_settle();
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        size_setting  = size;
        rebase_tops();
    endtask

    // Mostly ordinary words, with extremes and a narrow band to get repeats.
    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2, 3:    return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checker: the receiver cannot stall, so take every strobe
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string what, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    always @(posedge clk)
    begin
        tss_result_t want;
        if (rst_n && done)
        begin
            if (outcomes_due.size() == 0)
            begin
                note_mismatch("result with nothing pending", '0, result.data);
            end
            else
            begin
                want = outcomes_due.pop_front();
                if (result.status !== want.status)
                    note_mismatch("status", WORD_W'(want.status), WORD_W'(result.status));
                if (result.data !== want.data)
                    note_mismatch("data", want.data, result.data);
            end
        end
    end

    // Watchdog: end the run if no transfer of any kind happens for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("three_stacks_shared_memory test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset size 4: invalid stack, unused command, word extremes, full,
    // search reaching the bottom entry, empty pop and empty search.
    task automatic test_reset_size_cases();
        send_op(CMD_PUSH, SEL_NONE, 32'sh1111_1111);
        send_op(CMD_POP, SEL_NONE, 32'sh0);
        send_op(CMD_SEARCH, SEL_NONE, 32'sh0);
        send_op(CMD_SPARE, SEL_THREE, 32'sh2222_2222);
        send_op(CMD_PUSH, SEL_ONE, 32'sh7fff_ffff);
        send_op(CMD_PUSH, SEL_ONE, 32'sh8000_0000);
        send_op(CMD_PUSH, SEL_ONE, 32'sh0);
        send_op(CMD_PUSH, SEL_ONE, -32'sd1);
        send_op(CMD_PUSH, SEL_ONE, 32'sh5);
        send_op(CMD_SEARCH, SEL_ONE, 32'sh7fff_ffff);
        send_op(CMD_SEARCH, SEL_ONE, 32'sh8000_0000);
        send_op(CMD_SEARCH, SEL_ONE, 32'sh1234_5678);
        send_op(CMD_POP, SEL_TWO, 32'sh0);
        send_op(CMD_SEARCH, SEL_TWO, 32'sh0);
        send_op(CMD_PUSH, SEL_THREE, 32'sha5a5_a5a5);
        send_op(CMD_POP, SEL_THREE, 32'sh0);
        repeat (5) send_op(CMD_POP, SEL_ONE, 32'sh0);
    endtask

    // Size zero makes every stack full and empty; size one fills at once.
    task automatic test_size_corners();
        write_stack_size(5'd0);
        send_op(CMD_PUSH, SEL_TWO, 32'sh3);
        send_op(CMD_POP, SEL_THREE, 32'sh0);
        send_op(CMD_SEARCH, SEL_ONE, 32'sh0);
        write_stack_size(5'd1);
        send_op(CMD_PUSH, SEL_THREE, 32'sh4242_4242);
        send_op(CMD_PUSH, SEL_THREE, 32'sh5);
        send_op(CMD_SEARCH, SEL_THREE, 32'sh4242_4242);
    endtask

    // One random phase at a given size. push_pct sets the push share among
    // push/pop so some phases fill the stacks and others drain them.
    task automatic run_random_phase(input logic [SIZE_W-1:0] size, input int count,
                                    input int push_pct);
        logic [1:0]               op, sel;
        logic signed [WORD_W-1:0] word;
        int unsigned              roll, slot, base, depth;
        write_stack_size(size);
        for (int n = 0; n < count; n++)
        begin
            // alternate between gapped traffic and back-to-back stretches
            if ($urandom_range(0, 39) == 0)
                steady_flow = !steady_flow;
            // now and then hold off until the block has answered everything
            if ($urandom_range(0, 149) == 0)
                drain_and_settle();

            sel  = ($urandom_range(0, 99) < 7) ? SEL_NONE : 2'($urandom_range(1, 3));
            roll = $urandom_range(0, 99);
            if (roll < 4)
                op = CMD_SPARE;
            else if (roll < 30)
                op = CMD_SEARCH;
            else if ($urandom_range(0, 99) < push_pct)
                op = CMD_PUSH;
            else
                op = CMD_POP;

            word = pick_word();
            // most searches look for a word that sits in the chosen stack
            if (op == CMD_SEARCH && sel != SEL_NONE && $urandom_range(0, 9) < 6)
            begin
                slot  = int'(sel) - 1;
                base  = slot * region_slots();
                depth = top_slot[slot] - base;
                if (depth > 0)
                    word = stack_words[base + $urandom_range(0, depth - 1)];
            end
            send_op(op, sel, word);
        end
        steady_flow = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_random_phase(5'd16, 400, 55);
        run_random_phase(5'd1, 150, 50);
        run_random_phase(5'd31, 300, 62);
        run_random_phase(5'd7, 250, 45);
        run_random_phase(5'd3, 200, 55);
        run_random_phase(5'd0, 60, 50);
        run_random_phase(5'd12, 300, 50);
        run_random_phase(5'd16, 240, 40);
    endtask

    initial
    begin
        foreach (stack_words[k])
            stack_words[k] = '0;
        size_setting = SIZE_W'(SIZE_RESET);
        rebase_tops();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_size_cases();
        test_size_corners();
        test_random_traffic();

        // wait out the last results and any trailing work, then judge
        drain_and_settle();
        if (fail_count == 0 && outcomes_due.size() == 0)
            $display("three_stacks_shared_memory test passed");
        else
            $display("three_stacks_shared_memory test failed");
        $finish;
    end

endmodule
